// ===== hdl/sjs_pkg.sv =====
// shared types and constants for the set jaccard similarity block
`timescale 1ns / 1ps
package sjs_pkg;
	localparam int Capacity = 4096;
	localparam int FractionBits = 16;
	localparam int AddrW = $clog2(Capacity);
	localparam int CountW = AddrW + 1;
	localparam int SimW = FractionBits + 1;
	localparam int KeyW = 64;

	typedef enum logic [1:0] {
		FUNC_ADD_A = 2'd0,
		FUNC_ADD_B = 2'd1,
		FUNC_FINISH = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef struct packed {
		logic hash_ld;
		logic step_slot;
		logic do_write;
		logic clr_issue;
		logic div_start;
		logic res_clear;
	} cmd_t;

	typedef struct packed {
		logic slot_empty;
		logic key_hit;
		logic mark_has;
		logic table_full;
		logic clr_done;
		logic div_done;
	} stat_t;
endpackage

// ===== hdl/sjs_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
module sjs_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== hdl/sjs_div.sv =====
// restoring divider for the similarity ratio, one quotient bit per cycle
`timescale 1ns / 1ps
module sjs_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [sjs_pkg::CountW-1:0] num,
	input logic [sjs_pkg::CountW-1:0] den,
	output logic done,
	output logic [sjs_pkg::SimW-1:0] quo
);
	import sjs_pkg::*;
	localparam int NumW = CountW + FractionBits;
	localparam int CntW = $clog2(NumW + 1);
	logic [NumW-1:0] n_q;
	logic [CountW-1:0] r_q;
	logic [CountW-1:0] d_q;
	logic [CntW-1:0] cnt_q;
	logic busy_q;
	logic [CountW:0] trial;
	logic [CountW:0] diff;
	assign trial = {r_q, n_q[NumW-1]};
	assign diff = trial - {1'b0, d_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= {num, {FractionBits{1'b0}}};
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			n_q <= {n_q[NumW-2:0], ~diff[CountW]};
			r_q <= diff[CountW] ? trial[CountW-1:0] : diff[CountW-1:0];
		end
	end
	assign quo = n_q[SimW-1:0];
endmodule

// ===== hdl/sjs_datapath.sv =====
// hash, probe address, table memories, counters and result registers
`timescale 1ns / 1ps
module sjs_datapath (
	input logic clk,
	input logic arst_n,
	input sjs_pkg::cmd_t cmd,
	output sjs_pkg::stat_t stat,
	input logic [1:0] func,
	input logic [63:0] element,
	output logic [12:0] common_count,
	output logic [12:0] union_count,
	output logic [16:0] similarity,
	output logic empty_flag,
	output logic overflow_flag
);
	import sjs_pkg::*;
	// only product bits up to the top of the second xor fold reach the slot
	localparam int HashW = AddrW + 33;
	localparam int LoW = 23;
	localparam int HiW = HashW - LoW;
	localparam logic [HashW-1:0] HashMul = HashW'(64'hFF51AFD7ED558CCD);
	logic [KeyW-1:0] elem_q;
	logic [1:0] bit_q;
	logic [HashW-1:0] h1_s1;
	logic [HashW-1:0] pp_lo_s2;
	logic [HiW-1:0] pp_mid_s2;
	logic [HashW-1:0] h2;
	logic [AddrW-1:0] slot_q;
	logic [CountW-1:0] tries_q;
	logic [CountW-1:0] common_q;
	logic [CountW-1:0] union_q;
	logic dropped_q;
	logic [AddrW-1:0] clr_q;
	logic clr_busy_q;
	logic [AddrW-1:0] addr;
	logic key_we;
	logic mark_we;
	logic [1:0] mark_wd;
	logic [KeyW-1:0] key_rd;
	logic [1:0] mark_rd;
	logic div_done;
	logic [SimW-1:0] quo;
	logic [1:0] ld_q;

	assign addr = clr_busy_q ? clr_q : slot_q;
	assign key_we = cmd.do_write && (mark_rd == 2'b00);
	assign mark_we = cmd.do_write || clr_busy_q;
	assign mark_wd = clr_busy_q ? 2'b00 : (mark_rd | bit_q);

	sjs_ram #(.Width(KeyW), .Depth(Capacity)) u_key (
		.clk(clk), .we(key_we), .addr(addr), .wdata(elem_q), .rdata(key_rd)
	);
	sjs_ram #(.Width(2), .Depth(Capacity)) u_mark (
		.clk(clk), .we(mark_we), .addr(addr), .wdata(mark_wd), .rdata(mark_rd)
	);

	// split multiply, the high by high partial product falls above the kept bits
	always_ff @(posedge clk) begin
		if (cmd.hash_ld) begin
			elem_q <= element;
			bit_q <= (func == FUNC_ADD_A) ? 2'b01 : 2'b10;
			h1_s1 <= HashW'(element ^ (element >> 33));
		end
		pp_lo_s2 <= HashW'((2*LoW)'(h1_s1[LoW-1:0]) * (2*LoW)'(HashMul[LoW-1:0]));
		pp_mid_s2 <= HiW'(h1_s1[LoW-1:0] * HashMul[HashW-1:LoW]) +
			HiW'(h1_s1[HashW-1:LoW] * HashMul[LoW-1:0]);
	end

	assign h2 = {pp_mid_s2, {LoW{1'b0}}} + pp_lo_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_q <= '0;
			slot_q <= '0;
			tries_q <= '0;
			common_q <= '0;
			union_q <= '0;
			dropped_q <= 1'b0;
			clr_q <= '0;
			clr_busy_q <= 1'b1;
		end else begin
			ld_q <= {ld_q[0], cmd.hash_ld};
			if (ld_q[1]) begin
				slot_q <= h2[AddrW-1:0] ^ h2[AddrW+32:33];
				tries_q <= '0;
			end else if (cmd.step_slot) begin
				slot_q <= slot_q + 1'b1;
				tries_q <= tries_q + 1'b1;
			end
			if (cmd.do_write) begin
				if (mark_rd == 2'b00) begin
					union_q <= union_q + 1'b1;
				end else if ((mark_rd | bit_q) == 2'b11) begin
					common_q <= common_q + 1'b1;
				end
			end
			if (cmd.step_slot && tries_q == CountW'(Capacity - 1)) begin
				dropped_q <= 1'b1;
			end
			if (cmd.res_clear) begin
				common_q <= '0;
				union_q <= '0;
				dropped_q <= 1'b0;
			end
			if (cmd.clr_issue) begin
				clr_busy_q <= 1'b1;
				clr_q <= '0;
			end else if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == AddrW'(Capacity - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	sjs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(common_q), .den(union_q), .done(div_done), .quo(quo)
	);

	always_ff @(posedge clk) begin
		if (div_done) begin
			common_count <= 13'(common_q);
			union_count <= 13'(union_q);
			empty_flag <= (union_q == '0);
			similarity <= (union_q == '0) ? '0 : 17'(quo);
			overflow_flag <= dropped_q;
		end
	end

	assign stat.slot_empty = (mark_rd == 2'b00);
	assign stat.key_hit = (key_rd == elem_q);
	assign stat.mark_has = ((mark_rd & bit_q) != 2'b00);
	assign stat.table_full = (tries_q == CountW'(Capacity - 1));
	assign stat.clr_done = !clr_busy_q;
	assign stat.div_done = div_done;
endmodule

// ===== hdl/sjs_ctrl.sv =====
// controller state machine for probing, finishing and clearing
`timescale 1ns / 1ps
module sjs_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] func,
	output logic out_valid,
	input logic out_ready,
	output sjs_pkg::cmd_t cmd,
	input sjs_pkg::stat_t stat
);
	import sjs_pkg::*;
	typedef enum logic [7:0] {
		S_CLEAR = 8'b00000001,
		S_IDLE = 8'b00000010,
		S_HASH1 = 8'b00000100,
		S_HASH2 = 8'b00001000,
		S_READ = 8'b00010000,
		S_CHECK = 8'b00100000,
		S_DIV = 8'b01000000,
		S_OUT = 8'b10000000
	} state_t;
	state_t state_q;
	logic acc;
	assign in_ready = (state_q == S_IDLE);
	assign acc = in_valid && in_ready;
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.hash_ld = acc;
		cmd.div_start = acc && (func == FUNC_FINISH);
		if (state_q == S_CHECK) begin
			if (stat.slot_empty || (stat.key_hit && !stat.mark_has)) begin
				cmd.do_write = 1'b1;
			end else if (!stat.key_hit) begin
				cmd.step_slot = 1'b1;
			end
		end
		if (state_q == S_OUT && out_ready) begin
			cmd.clr_issue = 1'b1;
			cmd.res_clear = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: if (stat.clr_done) state_q <= S_IDLE;
				S_IDLE: begin
					if (acc) begin
						if (func == FUNC_FINISH) state_q <= S_DIV;
						else if (func != FUNC_NONE) state_q <= S_HASH1;
					end
				end
				S_HASH1: state_q <= S_HASH2;
				S_HASH2: state_q <= S_READ;
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (stat.slot_empty || stat.key_hit) state_q <= S_IDLE;
					else if (stat.table_full) state_q <= S_IDLE;
					else state_q <= S_READ;
				end
				S_DIV: if (stat.div_done) state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_CLEAR;
				default: state_q <= S_CLEAR;
			endcase
		end
	end
endmodule

// ===== hdl/set_jaccard_similarity.sv =====
// top level of the set jaccard similarity block
//  channel | dir | fields
//  in      | in  | func, element
//  out     | out | common_count, union_count, similarity, empty_flag, overflow_flag
// an element beat hashes, then probes by linear probing, one more probe per collision
// a finish beat runs the serial divider, then waits for out_ready
// after reset and after each result the mark memory is cleared, one slot a cycle
// in_ready is low while an item is in work or the clear runs
`timescale 1ns / 1ps
module set_jaccard_similarity (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] func,
	input logic [63:0] element,
	output logic out_valid,
	input logic out_ready,
	output logic [12:0] common_count,
	output logic [12:0] union_count,
	output logic [16:0] similarity,
	output logic empty_flag,
	output logic overflow_flag
);
	import sjs_pkg::*;
	cmd_t cmd;
	stat_t stat;
	sjs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.func(func), .out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .stat(stat)
	);
	sjs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.func(func), .element(element),
		.common_count(common_count), .union_count(union_count),
		.similarity(similarity), .empty_flag(empty_flag),
		.overflow_flag(overflow_flag)
	);
endmodule

// ===== hdl/sjs_checker.sv =====
// port level checks for the set jaccard similarity block
`timescale 1ns / 1ps
module sjs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [12:0] common_count,
	input logic [12:0] union_count,
	input logic [16:0] similarity,
	input logic empty_flag
);
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(similarity))
		else $error("result dropped");
	a_common_le_union: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> common_count <= union_count) else $error("common above union");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_flag |-> union_count == 13'd0 && similarity == 17'd0)
		else $error("bad empty result");
endmodule

bind set_jaccard_similarity sjs_checker u_sjs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .common_count(common_count),
	.union_count(union_count), .similarity(similarity), .empty_flag(empty_flag)
);

// ===== test/set_jaccard_similarity_test.sv =====
// self-checking testbench for the set jaccard similarity block
`timescale 1ns / 1ps
module set_jaccard_similarity_test;
	import sjs_pkg::*;

	typedef struct {
		logic [12:0] common;
		logic [12:0] uni;
		logic [16:0] sim;
		logic empty;
		logic ovf;
	} report_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] func;
	logic [63:0] element;
	logic out_valid;
	logic out_ready;
	logic [12:0] common_count;
	logic [12:0] union_count;
	logic [16:0] similarity;
	logic empty_flag;
	logic overflow_flag;

	set_jaccard_similarity uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.func(func), .element(element), .out_valid(out_valid), .out_ready(out_ready),
		.common_count(common_count), .union_count(union_count),
		.similarity(similarity), .empty_flag(empty_flag), .overflow_flag(overflow_flag)
	);

	bit [63:0] keys [Capacity];
	bit [1:0] marks [Capacity];
	int unsigned n_common;
	int unsigned n_union;
	bit dropped;
	report_t pending_reports [$];

	int errors;
	int beats_sent;
	int reports_seen;
	int tx_idle;
	int rx_stall;
	int hold_cycles;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("timeout at %0t", $time);
		$display("Some tests failed");
		$finish;
	end

	function automatic int unsigned slot_of(bit [63:0] v);
		v ^= v >> 33;
		v *= 64'hFF51AFD7ED558CCD;
		v ^= v >> 33;
		return int'(v % Capacity);
	endfunction

	function automatic void clear_sets();
		foreach (marks[i]) marks[i] = 2'b00;
		n_common = 0;
		n_union = 0;
		dropped = 0;
	endfunction

	function automatic void insert_value(bit [63:0] v, bit [1:0] m);
		int unsigned s;
		s = slot_of(v);
		for (int t = 0; t < Capacity; t++) begin
			if (marks[s] == 2'b00) begin
				keys[s] = v;
				marks[s] = m;
				n_union++;
				return;
			end
			if (keys[s] == v) begin
				if ((marks[s] & m) == 0) begin
					marks[s] |= m;
					if (marks[s] == 2'b11) n_common++;
				end
				return;
			end
			s = (s + 1) % Capacity;
		end
		dropped = 1;
	endfunction

	function automatic void predict_beat(func_t f, bit [63:0] v);
		report_t r;
		case (f)
			FUNC_ADD_A: insert_value(v, 2'b01);
			FUNC_ADD_B: insert_value(v, 2'b10);
			FUNC_FINISH: begin
				r.common = n_common[12:0];
				r.uni = n_union[12:0];
				r.empty = (n_union == 0);
				r.sim = (n_union == 0) ? 17'd0 :
					17'((64'(n_common) << FractionBits) / n_union);
				r.ovf = dropped;
				pending_reports.insert(pending_reports.size(), r);
				clear_sets();
			end
			default: ;
		endcase
	endfunction

	task automatic send_beat(func_t f, bit [63:0] v);
		@(negedge clk);
		if ($urandom_range(99) < tx_idle) begin
			in_valid <= 0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		in_valid <= 1;
		func <= f;
		element <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_beat(f, v);
		beats_sent++;
	endtask

	task automatic go_idle();
		@(negedge clk);
		in_valid <= 0;
		@(posedge clk);
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// receiver side
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 0;
				hold_cycles--;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall);
			end
		end
	end

	always @(posedge clk) begin
		report_t e;
		if (arst_n && out_valid && out_ready) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected result beat", $time);
				errors++;
			end else begin
				e = pending_reports.pop_front();
				if (common_count !== e.common) begin
					$display("%0t: common_count exp %0d got %0d", $time, e.common, common_count);
					errors++;
				end
				if (union_count !== e.uni) begin
					$display("%0t: union_count exp %0d got %0d", $time, e.uni, union_count);
					errors++;
				end
				if (similarity !== e.sim) begin
					$display("%0t: similarity exp %0d got %0d", $time, e.sim, similarity);
					errors++;
				end
				if (empty_flag !== e.empty) begin
					$display("%0t: empty_flag exp %0d got %0d", $time, e.empty, empty_flag);
					errors++;
				end
				if (overflow_flag !== e.ovf) begin
					$display("%0t: overflow_flag exp %0d got %0d", $time, e.ovf, overflow_flag);
					errors++;
				end
			end
		end
	end

	function automatic bit [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic test_directed();
		send_beat(FUNC_FINISH, 64'd0);
		send_beat(FUNC_ADD_A, 64'd0);
		send_beat(FUNC_ADD_A, '1);
		send_beat(FUNC_ADD_A, '1);
		send_beat(FUNC_ADD_B, '1);
		send_beat(FUNC_ADD_B, 64'd5);
		send_beat(FUNC_NONE, 64'd7);
		send_beat(FUNC_FINISH, '1);
		send_beat(FUNC_ADD_A, 64'h5555_5555_5555_5555);
		send_beat(FUNC_ADD_B, 64'h5555_5555_5555_5555);
		send_beat(FUNC_ADD_A, 64'hAAAA_AAAA_AAAA_AAAA);
		send_beat(FUNC_ADD_B, 64'hAAAA_AAAA_AAAA_AAAA);
		send_beat(FUNC_FINISH, 64'd0);
		send_beat(FUNC_ADD_B, 64'd9);
		send_beat(FUNC_ADD_B, 64'd9);
		send_beat(FUNC_FINISH, 64'd0);
		send_beat(FUNC_NONE, '1);
		send_beat(FUNC_FINISH, 64'd0);
		go_idle();
	endtask

	task automatic test_large_set();
		for (int i = 0; i < 600; i++)
			send_beat(FUNC_ADD_A, 64'(i) * 64'h9E37_79B9_7F4A_7C15);
		send_beat(FUNC_ADD_B, 64'd0);
		send_beat(FUNC_ADD_B, rand_word());
		send_beat(FUNC_FINISH, 64'd0);
		send_beat(FUNC_ADD_A, 64'd1);
		send_beat(FUNC_FINISH, 64'd0);
		go_idle();
	endtask

	task automatic test_random(int beats);
		bit [63:0] base;
		int n;
		int i;
		i = 0;
		while (i < beats) begin
			base = rand_word();
			n = $urandom_range(60, 1);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(9) == 0)
					send_beat(func_t'($urandom_range(3)), rand_word());
				else
					send_beat(func_t'($urandom_range(1)), base ^ 64'($urandom_range(40)));
			end
			send_beat(FUNC_FINISH, rand_word());
			i += n + 1;
		end
		go_idle();
	endtask

	task automatic test_backpressure();
		send_beat(FUNC_ADD_A, 64'd3);
		send_beat(FUNC_ADD_B, 64'd3);
		@(negedge clk);
		hold_cycles = 3000;
		send_beat(FUNC_FINISH, 64'd0);
		for (int k = 0; k < 20; k++) send_beat(func_t'($urandom_range(1)), rand_word());
		send_beat(FUNC_FINISH, 64'd0);
		go_idle();
	endtask

	initial begin
		errors = 0;
		beats_sent = 0;
		reports_seen = 0;
		hold_cycles = 0;
		tx_idle = 0;
		rx_stall = 0;
		in_valid = 0;
		func = FUNC_ADD_A;
		element = '0;
		clear_sets();
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_large_set();
		test_backpressure();
		test_random(250);
		tx_idle = 51;
		test_random(250);
		tx_idle = 0;
		rx_stall = 51;
		test_random(250);
		tx_idle = 35;
		rx_stall = 35;
		test_random(250);
		$display("sent %0d beats and checked %0d reports", beats_sent, reports_seen);
		$display("covered empty sets, duplicates, a large set, back pressure and random idling");
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ===== set_jaccard_similarity.f =====
hdl/sjs_pkg.sv
hdl/sjs_ram.sv
hdl/sjs_div.sv
hdl/sjs_datapath.sv
hdl/sjs_ctrl.sv
hdl/set_jaccard_similarity.sv
hdl/sjs_checker.sv
test/set_jaccard_similarity_test.sv
